/* hdl/pig_pkg.sv */
// Shared types and constants for the pixel invert / sRGB gray pipeline.
// Holds the luma weights, the index scaling constants and the encode curve
// level table built at elaboration. No dependencies.
package pig_pkg;

  // Width of the luma index into the encode curve
  localparam int unsigned LUMA_INDEX_BITS = 12;
  localparam int unsigned IDX_MAX         = (1 << LUMA_INDEX_BITS) - 1;

  // Pixel and output level widths
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PIXEL_W  = 3 * CHAN_W;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned LEVELS   = 1 << LEVEL_W;
  localparam int unsigned START_W  = LUMA_INDEX_BITS + 1;

  // Q16 luma weights; they sum to 65536
  localparam int unsigned LUMA_W = 24;
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  // k = round(IDX_MAX * L / (255 * 2^16)), split into a shift and a divide by 255
  localparam int unsigned SCALED_W   = LUMA_W + LUMA_INDEX_BITS;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned QUOT_W     = SCALED_W - FRAC_BITS;
  localparam int unsigned RECIP_W    = QUOT_W - 7;
  localparam int unsigned RPROD_W    = QUOT_W + RECIP_W;
  localparam longint unsigned RECIP  = (64'd1 << QUOT_W) / 255;
  localparam longint unsigned HALF_SCALE = 255 * 32768;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;

  // One pixel and its mode, carried down the pipeline
  typedef struct packed {
    logic              gray;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pig_beat_t;

  // Wide integers for building the level table at elaboration
  typedef logic [255:0] wide_t;
  typedef logic [LEVELS-1:0][START_W-1:0] level_start_t;

  function automatic wide_t wide_pow(input wide_t base, input int unsigned e);
    wide_t acc;
    acc = wide_t'(1);
    for (int unsigned i = 0; i < e; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // True when the encoded level at index k is at least v
  function automatic logic reaches_level(input longint unsigned k,
                                         input longint unsigned v,
                                         input wide_t d12,
                                         input wide_t bound);
    longint unsigned n;
    wide_t lhs;
    n = longint'(IDX_MAX);
    if (k * 64'd10000000 <= 64'd31308 * n) begin
      return (64'd32946 * k >= 64'd10 * n * v);
    end
    lhs = wide_pow(wide_t'(k), 5) * d12;
    return (lhs >= bound);
  endfunction

  // First index whose encoded level reaches v, for every v
  function automatic level_start_t build_level_start();
    level_start_t tab;
    wide_t d12;
    wide_t n5;
    wide_t bound;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    d12 = wide_pow(wide_t'(10761), 12);
    n5  = wide_pow(wide_t'(IDX_MAX), 5);
    for (int unsigned v = 0; v < LEVELS; v++) begin
      bound = wide_pow(wide_t'(40 * v + 561), 12) * n5;
      lo = 0;
      hi = longint'(IDX_MAX) + 1;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (reaches_level(mid, longint'(v), d12, bound)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      tab[v] = START_W'(lo);
    end
    return tab;
  endfunction

  localparam level_start_t LEVEL_START = build_level_start();

endpackage

/* hdl/pixel_invert_or_srgb_gray.sv */
// Pixel invert or sRGB grayscale, top level; uses pig_pkg, pig_luma, pig_curve, pig_skid.
// Takes one 24-bit pixel (blue in the low byte) per beat and returns one pixel.
// With mode 0 every byte is complemented; with mode 1 the Q16 luma
// 13933*R + 46871*G + 4732*B is rounded to a 12-bit index and mapped through the
// sRGB encode curve, and the level goes to all three bytes. One pixel is taken
// every clock cycle unless stalled. Stages: five luma/index, eight curve search (one
// level bit each), then the output register. When the output is stalled the skid entry
// takes one more beat, then the whole pipeline holds. Mode is written over the APB port
// at address 0; the user must do so only while no pixel is in flight (not enforced).
module pixel_invert_or_srgb_gray (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // blue_in [7:0], green_in [15:8], red_in [23:16]
  input  logic [pig_pkg::PIXEL_W-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // blue_out [7:0], green_out [15:8], red_out [23:16]
  output logic [pig_pkg::PIXEL_W-1:0]   m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pig_pkg::*;

  logic                       mode_q;
  logic                       pipe_en;
  pig_beat_t                  beat_in;
  logic                       luma_valid;
  pig_beat_t                  luma_beat;
  logic [LUMA_INDEX_BITS-1:0] luma_index;
  logic                       curve_valid;
  pig_beat_t                  curve_beat;
  logic [LEVEL_W-1:0]         curve_level;
  logic [PIXEL_W-1:0]         pixel_out;
  logic                       reg_hit;

  // Configuration register
  assign reg_hit = (paddr[2] == REG_MODE);
  assign pready  = 1'b1;
  assign prdata  = (psel && reg_hit) ? {31'b0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      mode_q <= pwdata[0];
    end
  end

  // Tag each beat with the mode it was taken under
  assign beat_in = '{gray:  mode_q,
                     red:   s_axis_tdata[23:16],
                     green: s_axis_tdata[15:8],
                     blue:  s_axis_tdata[7:0]};
  assign s_axis_tready = pipe_en;

  pig_luma u_luma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid),
    .beat_i  (beat_in),
    .valid_o (luma_valid),
    .beat_o  (luma_beat),
    .index_o (luma_index)
  );

  pig_curve u_curve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (luma_valid),
    .beat_i  (luma_beat),
    .index_i (luma_index),
    .valid_o (curve_valid),
    .beat_o  (curve_beat),
    .level_o (curve_level)
  );

  // Select gray level or inverted bytes
  assign pixel_out = curve_beat.gray ? {curve_level, curve_level, curve_level}
                                     : ~{curve_beat.red, curve_beat.green, curve_beat.blue};

  pig_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (curve_valid),
    .ready_o (pipe_en),
    .data_i  (pixel_out),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

/* hdl/pig_luma.sv */
// Luma and curve index stages: weighted sum, scale to the index range, divide by 255.
// Five register stages advancing together on en_i. Depends on pig_pkg.
module pig_luma (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  pig_pkg::pig_beat_t                   beat_i,
  output logic                                 valid_o,
  output pig_pkg::pig_beat_t                   beat_o,
  output logic [pig_pkg::LUMA_INDEX_BITS-1:0]  index_o
);
  import pig_pkg::*;

  localparam int unsigned STAGES = 5;

  logic [STAGES-1:0]          valid_q;
  pig_beat_t                  beat_q [STAGES];
  logic [LUMA_W-1:0]          red_part_q;
  logic [LUMA_W-1:0]          green_part_q;
  logic [LUMA_W-1:0]          blue_part_q;
  logic [LUMA_W-1:0]          luma_q;
  logic [QUOT_W-1:0]          coarse_q;
  logic [QUOT_W-1:0]          coarse_hold_q;
  logic [RPROD_W-1:0]         rprod_q;
  logic [LUMA_INDEX_BITS-1:0] index_q;

  logic [SCALED_W-1:0]        scaled;
  logic [RECIP_W-1:0]         quot_est;
  logic [QUOT_W-1:0]          rem;
  logic [RECIP_W-1:0]         quot;
  logic [LUMA_INDEX_BITS-1:0] index_d;

  // Scale luma to the index range with round half up, then drop the Q16 fraction
  assign scaled = SCALED_W'(luma_q) * SCALED_W'(IDX_MAX) + SCALED_W'(HALF_SCALE);

  // Reciprocal estimate falls short by at most one; fix with one compare
  assign quot_est = rprod_q[RPROD_W-1:QUOT_W];
  assign rem      = coarse_hold_q - ((QUOT_W'(quot_est) << 8) - QUOT_W'(quot_est));
  assign quot     = quot_est + RECIP_W'(rem >= QUOT_W'(255));
  assign index_d  = (quot > RECIP_W'(IDX_MAX)) ? LUMA_INDEX_BITS'(IDX_MAX)
                                               : quot[LUMA_INDEX_BITS-1:0];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[STAGES-2:0], valid_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q[0] <= beat_i;
      for (int i = 1; i < STAGES; i++) begin
        beat_q[i] <= beat_q[i-1];
      end
      red_part_q    <= LUMA_W'(W_RED)   * LUMA_W'(beat_i.red);
      green_part_q  <= LUMA_W'(W_GREEN) * LUMA_W'(beat_i.green);
      blue_part_q   <= LUMA_W'(W_BLUE)  * LUMA_W'(beat_i.blue);
      luma_q        <= red_part_q + green_part_q + blue_part_q;
      coarse_q      <= scaled[SCALED_W-1:FRAC_BITS];
      rprod_q       <= RPROD_W'(coarse_q) * RPROD_W'(RECIP);
      coarse_hold_q <= coarse_q;
      index_q       <= index_d;
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign beat_o  = beat_q[STAGES-1];
  assign index_o = index_q;

`ifndef SYNTHESIS
  a_white_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && beat_o.red == 8'hFF && beat_o.green == 8'hFF && beat_o.blue == 8'hFF)
    |-> (index_o == LUMA_INDEX_BITS'(IDX_MAX)))
    else $error("white pixel did not map to the top curve index");
  a_black_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && beat_o.red == 8'h00 && beat_o.green == 8'h00 && beat_o.blue == 8'h00)
    |-> (index_o == '0))
    else $error("black pixel did not map to curve index zero");
`endif

endmodule

/* hdl/pig_curve.sv */
// sRGB encode curve lookup: binary search of the level start table, one bit a stage.
// Eight register stages advancing together on en_i. Depends on pig_pkg.
module pig_curve (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  pig_pkg::pig_beat_t                   beat_i,
  input  logic [pig_pkg::LUMA_INDEX_BITS-1:0]  index_i,
  output logic                                 valid_o,
  output pig_pkg::pig_beat_t                   beat_o,
  output logic [pig_pkg::LEVEL_W-1:0]          level_o
);
  import pig_pkg::*;

  logic [LEVEL_W-1:0]         valid_q;
  pig_beat_t                  beat_q  [LEVEL_W];
  logic [LUMA_INDEX_BITS-1:0] index_q [LEVEL_W];
  logic [LEVEL_W-1:0]         level_q [LEVEL_W];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[LEVEL_W-2:0], valid_i};
    end
  end

  // Each stage settles one level bit, most significant first
  for (genvar j = 0; j < LEVEL_W; j++) begin : g_step
    logic [LUMA_INDEX_BITS-1:0] idx_in;
    logic [LEVEL_W-1:0]         lvl_in;
    logic [LEVEL_W-1:0]         cand;
    pig_beat_t                  beat_in;

    if (j == 0) begin : g_head
      assign idx_in  = index_i;
      assign lvl_in  = '0;
      assign beat_in = beat_i;
    end else begin : g_body
      assign idx_in  = index_q[j-1];
      assign lvl_in  = level_q[j-1];
      assign beat_in = beat_q[j-1];
    end

    assign cand = lvl_in | (LEVEL_W'(1) << (LEVEL_W - 1 - j));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        index_q[j] <= idx_in;
        beat_q[j]  <= beat_in;
        level_q[j] <= (LEVEL_START[cand] <= {1'b0, idx_in}) ? cand : lvl_in;
      end
    end
  end

  assign valid_o = valid_q[LEVEL_W-1];
  assign beat_o  = beat_q[LEVEL_W-1];
  assign level_o = level_q[LEVEL_W-1];

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(valid_o) && $stable(valid_q)))
    else $error("curve pipeline moved while stalled");
`endif

endmodule

/* hdl/pig_skid.sv */
// Output register with one skid entry, so the pipeline runs while a beat waits.
// Ready toward the pipeline comes from a register. Depends on pig_pkg.
module pig_skid (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [pig_pkg::PIXEL_W-1:0]  data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [pig_pkg::PIXEL_W-1:0]  data_o
);
  import pig_pkg::*;

  logic               out_valid_q;
  logic               skid_valid_q;
  logic [PIXEL_W-1:0] out_q;
  logic [PIXEL_W-1:0] skid_q;
  logic               take_in;
  logic               out_free;

  assign ready_o  = !skid_valid_q;
  assign take_in  = valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || ready_i;

  // Refill the output from the skid entry first, else from the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= take_in;
      end
    end else if (take_in) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (take_in) begin
        out_q <= data_i;
      end
    end else if (take_in) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with an empty output register");
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && ready_i) |=> !skid_valid_q)
    else $error("skid entry not drained after output beat");
`endif

endmodule
